[src/h264fu_pkg.sv]
// h264fu_pkg: shared types and constants for the H.264 FU-A packetizer
// used by h264_rtp_fu_a_packetizer_unit, h264fu_checker and the bench; no dependencies
`default_nettype none

package h264fu_pkg;

  // default sizing of the unit and fragment counters
  localparam int DEF_MAX_UNIT_BYTES     = 65536;
  localparam int DEF_MAX_FRAGMENT_BYTES = 4095;

  // configuration register reset values
  localparam int          RESET_MAX_FRAG = 1300;
  localparam logic [31:0] RESET_TS_STEP  = 32'(90000 / 25);

  // NAL / FU-A header fields
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] FU_START  = 8'h80;
  localparam logic [7:0] FU_END    = 8'h40;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_FRAG_PAYLOAD = 1'b0,
    CFG_TIMESTAMP_STEP   = 1'b1
  } cfg_idx_t;

  // tdata / tuser widths of the result channel, tdata width of the input channel
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;
  localparam int IN_TDATA_W  = 32;

  // one result transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] sequence_number;
    logic [31:0] packet_timestamp;
    logic        item_done;
  } res_t;

endpackage : h264fu_pkg

`default_nettype wire

[src/h264_rtp_fu_a_packetizer_unit.sv]
// h264_rtp_fu_a_packetizer_unit: splits NAL units into single packets or FU-A fragments
// depends on h264fu_pkg
//
//  channel | direction | tdata (low bit first)                      | tuser / tlast
//  in_     | slave     | data_byte[7:0], unit_length[24:8], 0 pad   | tuser: unit_start
//  out_    | master    | out_byte, sequence_number, packet_timestamp| tuser: packet_first,
//          |           |                                            | item_done; tlast: last
//  cfg_    | write     | index 0 max_fragment_payload, 1 timestamp_step
//
// An input byte is taken into an input register, decoded combinationally and its 0 to 3
// result transactions appended to a 4-entry output queue; results leave one per cycle
// while out_tready is high. Input accepted every cycle while the queue holds at most one
// result, so plain payload bytes flow at 1 byte/cycle while out_tready stays high; a
// fragment start adds the FU indicator and FU header. rst_n is synchronous, active low.
`default_nettype none

module h264_rtp_fu_a_packetizer_unit
  import h264fu_pkg::*;
#(
  parameter int MAX_UNIT_BYTES     = DEF_MAX_UNIT_BYTES,
  parameter int MAX_FRAGMENT_BYTES = DEF_MAX_FRAGMENT_BYTES
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // data_byte[7:0], unit_length[24:8]
  input  wire logic                    in_tuser,   // unit_start
  // result stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // out_byte, sequence_number, timestamp
  output logic [OUT_TUSER_W-1:0]       out_tuser,  // packet_first, item_done
  output logic                         out_tlast,  // packet_last
  // configuration
  input  wire logic                    cfg_wen,
  input  wire logic [0:0]              cfg_addr,
  input  wire logic [31:0]             cfg_wdata
);

  localparam int LEFT_W = $clog2(MAX_UNIT_BYTES);
  localparam int FRAG_W = $clog2(MAX_FRAGMENT_BYTES + 1);
  localparam int RST_LIMIT = (RESET_MAX_FRAG > MAX_FRAGMENT_BYTES) ?
                             MAX_FRAGMENT_BYTES : RESET_MAX_FRAG;
  localparam int QD = 4;
  localparam int QC_W = 3;

  // configuration registers
  logic [FRAG_W-1:0] maxp_r;
  logic [31:0]       ts_step_r;
  logic [31:0]       cfg_lim;

  // input register
  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_start_r;
  logic [16:0]       in_len_r;

  // packetizer state
  logic [15:0]       seq_r, seq_nxt;
  logic [31:0]       ts_r, ts_nxt;
  logic [7:0]        hdr_r, hdr_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [FRAG_W-1:0] fbu_r, fbu_nxt;
  logic              frag_r, frag_nxt;
  logic              ffp_r, ffp_nxt;

  // decode
  logic              take;
  logic [31:0]       len_c;
  logic [FRAG_W:0]   fbu_inc;
  logic              frag_end;
  logic [7:0]        fuh;
  res_t              res [3];
  logic [1:0]        nres;

  // output queue
  res_t              q_r [QD];
  res_t              q_sh [QD];
  res_t              q_nxt [QD];
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  logic              pop;
  logic [QC_W-1:0]   base;
  logic [QC_W-1:0]   off;

  // effective fragment size of a configuration write
  always_comb begin
    cfg_lim = {20'd0, cfg_wdata[11:0]};
    if (cfg_lim == 32'd0) begin
      cfg_lim = 32'd1;
    end
    if (cfg_lim > 32'(MAX_FRAGMENT_BYTES)) begin
      cfg_lim = 32'(MAX_FRAGMENT_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxp_r    <= FRAG_W'(RST_LIMIT);
      ts_step_r <= RESET_TS_STEP;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MAX_FRAG_PAYLOAD: maxp_r    <= FRAG_W'(cfg_lim);
        CFG_TIMESTAMP_STEP:   ts_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage moves on when the queue has room for three results
  assign take      = in_vld_r && (cnt_r <= QC_W'(1));
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata[7:0];
      in_len_r   <= in_tdata[24:8];
      in_start_r <= in_tuser;
    end
  end

  // decode one byte into state update and up to three results
  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    hdr_nxt  = hdr_r;
    left_nxt = left_r;
    fbu_nxt  = fbu_r;
    frag_nxt = frag_r;
    ffp_nxt  = ffp_r;
    nres     = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
      res[k].packet_timestamp = ts_r;
    end

    len_c = {15'd0, in_len_r};
    if (len_c == 32'd0) begin
      len_c = 32'd1;
    end
    if (len_c > 32'(MAX_UNIT_BYTES)) begin
      len_c = 32'(MAX_UNIT_BYTES);
    end

    fbu_inc  = {1'b0, fbu_r} + (FRAG_W + 1)'(1);
    frag_end = fbu_inc >= {1'b0, maxp_r};

    fuh = hdr_r & TYPE_MASK;
    if (ffp_r) begin
      fuh = fuh | FU_START;
    end
    if ({{(32 - LEFT_W){1'b0}}, left_r} <= 32'(maxp_r)) begin
      fuh = fuh | FU_END;
    end

    if (in_start_r) begin
      // unit header byte
      hdr_nxt  = in_byte_r;
      left_nxt = LEFT_W'(len_c - 32'd1);
      fbu_nxt  = '0;
      if ((len_c - 32'd1) <= 32'(maxp_r)) begin
        frag_nxt                = 1'b0;
        ffp_nxt                 = 1'b0;
        res[0].out_byte         = in_byte_r;
        res[0].packet_first     = 1'b1;
        res[0].packet_last      = (len_c == 32'd1);
        res[0].sequence_number  = seq_r;
        res[0].item_done        = 1'b1;
        nres                    = 2'd1;
        seq_nxt                 = seq_r + 16'd1;
        if (len_c == 32'd1) begin
          ts_nxt = ts_r + ts_step_r;
        end
      end else begin
        frag_nxt = 1'b1;
        ffp_nxt  = 1'b1;
      end
    end else if (left_r == '0) begin
      // no unit open
    end else if (!frag_r) begin
      // single packet payload byte
      res[0].out_byte    = in_byte_r;
      res[0].packet_last = (left_r == LEFT_W'(1));
      res[0].item_done   = 1'b1;
      nres               = 2'd1;
      left_nxt           = left_r - LEFT_W'(1);
      if (left_r == LEFT_W'(1)) begin
        ts_nxt = ts_r + ts_step_r;
      end
    end else begin
      // fragment payload byte, opened by FU indicator and FU header
      if (fbu_r == '0) begin
        res[0].out_byte        = (hdr_r & NRI_MASK) | FU_A_TYPE;
        res[0].packet_first    = 1'b1;
        res[0].sequence_number = seq_r;
        res[1].out_byte        = fuh;
        res[2].out_byte        = in_byte_r;
        res[2].packet_last     = (left_r == LEFT_W'(1)) || frag_end;
        res[2].item_done       = 1'b1;
        nres                   = 2'd3;
        seq_nxt                = seq_r + 16'd1;
        ffp_nxt                = 1'b0;
      end else begin
        res[0].out_byte    = in_byte_r;
        res[0].packet_last = (left_r == LEFT_W'(1)) || frag_end;
        res[0].item_done   = 1'b1;
        nres               = 2'd1;
      end
      left_nxt = left_r - LEFT_W'(1);
      fbu_nxt  = frag_end ? '0 : fbu_inc[FRAG_W-1:0];
      if (left_r == LEFT_W'(1)) begin
        frag_nxt = 1'b0;
        fbu_nxt  = '0;
        ts_nxt   = ts_r + ts_step_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      hdr_r  <= '0;
      left_r <= '0;
      fbu_r  <= '0;
      frag_r <= 1'b0;
      ffp_r  <= 1'b0;
    end else if (take) begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      hdr_r  <= hdr_nxt;
      left_r <= left_nxt;
      fbu_r  <= fbu_nxt;
      frag_r <= frag_nxt;
      ffp_r  <= ffp_nxt;
    end
  end

  // output queue: head at entry 0, shift on pop, append behind the survivors
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign base       = cnt_r - QC_W'(pop);

  always_comb begin
    for (int i = 0; i < QD - 1; i++) begin
      q_sh[i] = pop ? q_r[i + 1] : q_r[i];
    end
    q_sh[QD - 1] = q_r[QD - 1];
    for (int i = 0; i < QD; i++) begin
      off      = QC_W'(i) - base;
      q_nxt[i] = q_sh[i];
      if (take && (QC_W'(i) >= base) && (off < {1'b0, nres})) begin
        q_nxt[i] = res[off[1:0]];
      end
    end
    cnt_nxt = base + (take ? {1'b0, nres} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // result transaction fields
  assign out_tdata = {q_r[0].packet_timestamp, q_r[0].sequence_number, q_r[0].out_byte};
  assign out_tuser = {q_r[0].item_done, q_r[0].packet_first};
  assign out_tlast = q_r[0].packet_last;

endmodule : h264_rtp_fu_a_packetizer_unit

`default_nettype wire

[src/h264fu_checker.sv]
// h264fu_checker: port-level assertions for h264_rtp_fu_a_packetizer_unit, with its bind
// depends on h264fu_pkg
`default_nettype none

module h264fu_checker
  import h264fu_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tlast
);

  // result queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // sequence number only carried on a packet start
  a_seq_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[23:8] == 16'd0)
    else $error("sequence number outside packet start");

  // the closing byte of a packet is always the last result of its input byte
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("packet end without item done");

endmodule : h264fu_checker

bind h264_rtp_fu_a_packetizer_unit h264fu_checker u_h264fu_checker (.*);

`default_nettype wire

[dv/h264_rtp_fu_a_packetizer_unit_tb.sv]
// h264_rtp_fu_a_packetizer_unit_tb: self-checking bench for the FU-A packetizer
// drives NAL bytes with random gaps, predicts packets, checks every result transaction
// depends on h264fu_pkg and h264_rtp_fu_a_packetizer_unit
`default_nettype none

module h264_rtp_fu_a_packetizer_unit_tb;
  import h264fu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  // one input byte of a NAL unit
  typedef struct {
    logic [7:0]  data_byte;
    logic        unit_start;
    logic [16:0] unit_length;
  } nal_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_wen = 1'b0;
  logic [0:0]             cfg_addr = '0;
  logic [31:0]            cfg_wdata = '0;

  nal_item_t nal_bytes_q[$];
  res_t      expected_pkts[$];
  res_t      burst[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  // packetizer state mirror
  logic [11:0] frag_max = 12'(RESET_MAX_FRAG);
  logic [31:0] ts_step = RESET_TS_STEP;
  logic [15:0] seq_next = '0;
  logic [31:0] ts_now = '0;
  logic [7:0]  nal_hdr = '0;
  int unsigned bytes_left = 0;
  int unsigned frag_used = 0;
  bit          in_fu = 1'b0;
  bit          first_pend = 1'b0;

  h264_rtp_fu_a_packetizer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // one packet byte; a packet start takes the next sequence number
  function automatic void add_packet_byte(input logic [7:0] b, input bit first, input bit last);
    res_t r;
    r.out_byte         = b;
    r.packet_first     = first;
    r.packet_last      = last;
    r.sequence_number  = first ? seq_next : 16'h0;
    r.packet_timestamp = ts_now;
    r.item_done        = 1'b0;
    burst.push_back(r);
    if (first) seq_next = seq_next + 16'd1;
  endfunction

  // expected packet bytes caused by one accepted input byte
  function automatic void predict_packets(input nal_item_t it);
    int unsigned maxp;
    int unsigned len;
    logic [7:0]  fu_hdr;
    res_t        r;
    burst.delete();
    maxp = (frag_max == 12'd0) ? 1 : int'(frag_max);
    if (it.unit_start) begin
      len = it.unit_length;
      if (len == 0) len = 1;
      if (len > DEF_MAX_UNIT_BYTES) len = DEF_MAX_UNIT_BYTES;
      nal_hdr    = it.data_byte;
      bytes_left = len - 1;
      frag_used  = 0;
      if (len - 1 <= maxp) begin
        in_fu      = 1'b0;
        first_pend = 1'b0;
        add_packet_byte(it.data_byte, 1'b1, len == 1);
        if (len == 1) ts_now = ts_now + ts_step;
      end else begin
        // header held back, it travels in the FU bytes
        in_fu      = 1'b1;
        first_pend = 1'b1;
      end
    end else if (bytes_left == 0) begin
      // no unit open, byte dropped
    end else if (!in_fu) begin
      add_packet_byte(it.data_byte, 1'b0, bytes_left == 1);
      bytes_left--;
      if (bytes_left == 0) ts_now = ts_now + ts_step;
    end else begin
      // fragment opens with FU indicator and FU header
      if (frag_used == 0) begin
        fu_hdr = nal_hdr & TYPE_MASK;
        if (first_pend) fu_hdr = fu_hdr | FU_START;
        if (bytes_left <= maxp) fu_hdr = fu_hdr | FU_END;
        add_packet_byte((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0);
        add_packet_byte(fu_hdr, 1'b0, 1'b0);
        first_pend = 1'b0;
      end
      add_packet_byte(it.data_byte, 1'b0, bytes_left == 1 || frag_used + 1 >= maxp);
      bytes_left--;
      frag_used++;
      if (frag_used >= maxp) frag_used = 0;
      if (bytes_left == 0) begin
        in_fu     = 1'b0;
        frag_used = 0;
        ts_now    = ts_now + ts_step;
      end
    end
    if (burst.size() > 0) begin
      r = burst.pop_back();
      r.item_done = 1'b1;
      burst.push_back(r);
    end
    foreach (burst[i]) expected_pkts.push_back(burst[i]);
  endfunction

  // input driver with random idle bursts
  always @(posedge clk) begin : nal_driver
    int        idle_left;
    bit        next_valid;
    nal_item_t it;
    if (!rst_n) begin
      idle_left = 0;
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        it.data_byte   = in_tdata[7:0];
        it.unit_length = in_tdata[24:8];
        it.unit_start  = in_tuser;
        predict_packets(it);
      end
      next_valid = 1'b0;
      if (idle_left > 0 && !calm) begin
        idle_left--;
      end else if (nal_bytes_q.size() > 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(1, 8) - 1;
        end else begin
          it = nal_bytes_q.pop_front();
          in_tdata   <= {7'b0, it.unit_length, it.data_byte};
          in_tuser   <= it.unit_start;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result monitor with random stall bursts
  always @(posedge clk) begin : pkt_monitor
    int   stall_left;
    res_t exp_r;
    if (!rst_n) begin
      stall_left = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pkts.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual tdata %h tuser %b tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          exp_r = expected_pkts.pop_front();
          check_field("out_byte", 32'(exp_r.out_byte), 32'(out_tdata[7:0]));
          check_field("packet_first", 32'(exp_r.packet_first), 32'(out_tuser[0]));
          check_field("packet_last", 32'(exp_r.packet_last), 32'(out_tlast));
          check_field("sequence_number", 32'(exp_r.sequence_number), 32'(out_tdata[23:8]));
          check_field("packet_timestamp", exp_r.packet_timestamp, out_tdata[55:24]);
          check_field("item_done", 32'(exp_r.item_done), 32'(out_tuser[1]));
        end
      end
      if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MAX_FRAG_PAYLOAD) frag_max = val[11:0];
    else ts_step = val;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // hold the sender until every expected transaction is back, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (nal_bytes_q.size() != 0 || in_tvalid || expected_pkts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit st, input logic [16:0] len);
    nal_item_t it;
    it.data_byte   = b;
    it.unit_start  = st;
    it.unit_length = len;
    nal_bytes_q.push_back(it);
  endtask

  // mostly whole units with random content, some cut short, some noise
  task automatic queue_random_units(input int n_items);
    int count;
    int sel;
    int len;
    int sent;
    count = 0;
    while (count < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        push_byte(8'($urandom), 1'b0, 17'($urandom));
        count++;
      end else if (sel < 9) begin
        push_byte(8'($urandom), 1'b1, 17'($urandom_range(0, 1)));
        count++;
      end else if (sel < 11) begin
        sent = $urandom_range(0, 6);
        if (sent > n_items - count - 1) sent = n_items - count - 1;
        push_byte(8'($urandom), 1'b1, 17'($urandom_range(65536, 131071)));
        repeat (sent) push_byte(8'($urandom), 1'b0, 17'($urandom));
        count += sent + 1;
      end else begin
        len  = (sel < 90) ? $urandom_range(2, 30) : $urandom_range(31, 120);
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : len - 1;
        // a unit that does not fit the item budget is cut short
        if (sent > n_items - count - 1) sent = n_items - count - 1;
        push_byte(8'($urandom), 1'b1, 17'(len));
        repeat (sent) push_byte(8'($urandom), 1'b0, 17'($urandom));
        count += sent + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: lone header, zero length, stray byte, short single packet
    push_byte(8'hFF, 1'b1, 17'd1);
    push_byte(8'h00, 1'b1, 17'd0);
    push_byte(8'hAA, 1'b0, 17'd5);
    push_byte(8'h65, 1'b1, 17'd3);
    push_byte(8'h00, 1'b0, 17'd0);
    push_byte(8'hFF, 1'b0, 17'h1FFFF);
    // unit dropped by a new start, then an oversize unit left open
    push_byte(8'h67, 1'b1, 17'd10);
    push_byte(8'h11, 1'b0, 17'd0);
    push_byte(8'hE8, 1'b1, 17'd2);
    push_byte(8'h22, 1'b0, 17'd0);
    push_byte(8'h7C, 1'b1, 17'h1FFFF);
    push_byte(8'h33, 1'b0, 17'd0);
    push_byte(8'h44, 1'b0, 17'd0);
    push_byte(8'h55, 1'b0, 17'd0);
    wait_idle();

    // shrink the fragment size mid-unit, then a fragmented unit and an exact fit
    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'd3);
    push_byte(8'h66, 1'b0, 17'd0);
    push_byte(8'h77, 1'b0, 17'd0);
    push_byte(8'h9C, 1'b1, 17'd5);
    repeat (4) push_byte(8'($urandom), 1'b0, 17'd0);
    push_byte(8'h41, 1'b1, 17'd4);
    repeat (3) push_byte(8'($urandom), 1'b0, 17'd0);
    wait_idle();

    // zero fragment size acts as one, timestamp wraps
    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'd0);
    write_reg(CFG_TIMESTAMP_STEP, 32'hFFFF_FFFF);
    push_byte(8'h5C, 1'b1, 17'd3);
    push_byte(8'h01, 1'b0, 17'd0);
    push_byte(8'h02, 1'b0, 17'd0);
    wait_idle();

    // random phases over several register settings
    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'd1);
    write_reg(CFG_TIMESTAMP_STEP, 32'd0);
    queue_random_units(35);
    wait_idle();

    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'd4095);
    write_reg(CFG_TIMESTAMP_STEP, $urandom);
    queue_random_units(35);
    wait_idle();

    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'($urandom_range(2, 12)));
    write_reg(CFG_TIMESTAMP_STEP, $urandom);
    queue_random_units(20);
    wait_idle();
    queue_random_units(20);
    wait_idle();

    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'($urandom_range(13, 40)));
    queue_random_units(40);
    wait_idle();

    // last stretch runs without gaps or stalls
    write_reg(CFG_MAX_FRAG_PAYLOAD, 32'($urandom_range(2, 8)));
    write_reg(CFG_TIMESTAMP_STEP, $urandom);
    calm = 1'b1;
    queue_random_units(40);
    wait_idle();

    if (expected_pkts.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : h264_rtp_fu_a_packetizer_unit_tb

`default_nettype wire

[filelist.f]
src/h264fu_pkg.sv
src/h264_rtp_fu_a_packetizer_unit.sv
src/h264fu_checker.sv
dv/h264_rtp_fu_a_packetizer_unit_tb.sv
